// ===== rtl/core/sitrd_pkg.sv =====
// ----------------------------------------------------------------------------
// sitrd_pkg
// shared types and constants for the signed integer to radix digits block
// ----------------------------------------------------------------------------
package sitrd_pkg;

    localparam int VALUE_W       = 32;
    localparam int CHAR_W        = 8;
    localparam int RADIX_W       = 5;
    localparam int SYM_W         = 64;
    localparam int SYM_COUNT     = 16;
    localparam int SYM_IDX_W     = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_SYMBOLS_DEF = 16;

    // long division: quotient bits resolved per cycle
    localparam int BITS_PER_CYC  = 8;
    localparam int CYC_PER_DIV   = VALUE_W / BITS_PER_CYC;
    localparam int STEP_W        = $clog2(CYC_PER_DIV);

    // digit stack holds the longest text, base two
    localparam int STACK_DEPTH   = VALUE_W;
    localparam int COUNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [SYM_W-1:0]   SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [SYM_W-1:0]   SYMBOLS_HIGH_RESET = 64'h4645444342413938;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    typedef struct packed {
        logic load;      // capture input value and sign
        logic start;     // latch base, clear remainder and step count
        logic div_step;  // resolve one slice of quotient bits
        logic out_load;  // write output register
        logic out_sign;  // output register takes the minus sign
        logic pop;       // drop the top digit
    } t_dp_cmd;

    typedef struct packed {
        logic alpha_ok;
        logic div_last;
        logic quo_zero;
        logic neg;
        logic stack_one;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/sitrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitrd_ctrl
// sequencer: accept, alphabet check, digit division loop, character emission
// ----------------------------------------------------------------------------
module sitrd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sitrd_pkg::t_dp_status i_status,
    output sitrd_pkg::t_dp_cmd    o_cmd
);

    sitrd_pkg::t_state r_state;
    sitrd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitrd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sitrd_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sitrd_pkg::ST_CHECK;
            end
            sitrd_pkg::ST_CHECK: begin
                n_state = i_status.alpha_ok ? sitrd_pkg::ST_DIVIDE : sitrd_pkg::ST_IDLE;
            end
            sitrd_pkg::ST_DIVIDE: begin
                if (i_status.div_last && i_status.quo_zero) begin
                    n_state = i_status.neg ? sitrd_pkg::ST_SIGN : sitrd_pkg::ST_DIGITS;
                end
            end
            sitrd_pkg::ST_SIGN: begin
                if (i_status.out_free) n_state = sitrd_pkg::ST_DIGITS;
            end
            sitrd_pkg::ST_DIGITS: begin
                if (i_status.out_free && i_status.stack_one) n_state = sitrd_pkg::ST_IDLE;
            end
            default: n_state = sitrd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            sitrd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sitrd_pkg::ST_CHECK: begin
                o_cmd.start = i_status.alpha_ok;
            end
            sitrd_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            sitrd_pkg::ST_SIGN: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_sign = 1'b1;
            end
            sitrd_pkg::ST_DIGITS: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.pop      = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/sitrd_dp.sv =====
// ----------------------------------------------------------------------------
// sitrd_dp
// datapath: alphabet check, sliced long division, digit stack, output register
// ----------------------------------------------------------------------------
module sitrd_dp #(
    parameter int MAX_SYMBOLS = sitrd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sitrd_pkg::t_dp_cmd              i_cmd,
    output sitrd_pkg::t_dp_status           o_status,
    input  logic [sitrd_pkg::VALUE_W-1:0]   i_value,
    input  logic [sitrd_pkg::RADIX_W-1:0]   i_radix,
    input  logic [sitrd_pkg::SYM_W-1:0]     i_symbols_low,
    input  logic [sitrd_pkg::SYM_W-1:0]     i_symbols_high,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [sitrd_pkg::CHAR_W-1:0]    o_out_char,
    output logic                            o_out_last
);

    localparam int DIG_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
    localparam logic [sitrd_pkg::STEP_W-1:0] STEP_LAST =
        sitrd_pkg::STEP_W'(sitrd_pkg::CYC_PER_DIV - 1);

    logic [2*sitrd_pkg::SYM_W-1:0]  all_syms;
    logic [sitrd_pkg::CHAR_W-1:0]   syms [sitrd_pkg::SYM_COUNT];
    logic                           alpha_ok;
    logic                           r_alpha_ok;

    logic [sitrd_pkg::VALUE_W-1:0]  r_div;
    logic [sitrd_pkg::VALUE_W-1:0]  n_div;
    logic [sitrd_pkg::RADIX_W-1:0]  r_rem;
    logic [sitrd_pkg::RADIX_W-1:0]  n_rem;
    logic [sitrd_pkg::RADIX_W-1:0]  r_base;
    logic [sitrd_pkg::STEP_W-1:0]   r_step;
    logic                           r_neg;
    logic                           push;

    logic [DIG_W-1:0]               r_stack [sitrd_pkg::STACK_DEPTH];
    logic [sitrd_pkg::COUNT_W-1:0]  r_count;

    logic                           r_out_valid;
    logic [sitrd_pkg::CHAR_W-1:0]   r_out_char;
    logic                           r_out_last;
    logic [sitrd_pkg::SYM_IDX_W-1:0] top_idx;

    assign all_syms = {i_symbols_high, i_symbols_low};

    always_comb begin
        for (int i = 0; i < sitrd_pkg::SYM_COUNT; i++) begin
            syms[i] = all_syms[i*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W];
        end
    end

    // radix range, sign and pairwise compare over the symbols in use, registered
    always_comb begin
        alpha_ok = (i_radix >= sitrd_pkg::RADIX_W'(2)) &&
                   (i_radix <= sitrd_pkg::RADIX_W'(MAX_SYMBOLS));
        for (int i = 0; i < sitrd_pkg::SYM_COUNT; i++) begin
            if (sitrd_pkg::RADIX_W'(i) < i_radix) begin
                if (syms[i] == sitrd_pkg::CHAR_PLUS || syms[i] == sitrd_pkg::CHAR_MINUS) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < sitrd_pkg::SYM_COUNT; j++) begin
                    if (sitrd_pkg::RADIX_W'(j) < i_radix && syms[i] == syms[j]) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_ok <= 1'b0;
        end else begin
            r_alpha_ok <= alpha_ok;
        end
    end

    // restoring division, one slice of quotient bits per cycle
    always_comb begin
        logic [sitrd_pkg::RADIX_W-1:0] trial;
        n_div = r_div;
        n_rem = r_rem;
        for (int k = 0; k < sitrd_pkg::BITS_PER_CYC; k++) begin
            trial = {n_rem[sitrd_pkg::RADIX_W-2:0], n_div[sitrd_pkg::VALUE_W-1]};
            n_div = {n_div[sitrd_pkg::VALUE_W-2:0], 1'b0};
            if (trial >= r_base) begin
                n_rem    = trial - r_base;
                n_div[0] = 1'b1;
            end else begin
                n_rem = trial;
            end
        end
    end

    assign push = i_cmd.div_step && (r_step == STEP_LAST);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[sitrd_pkg::VALUE_W-1];
            r_div <= i_value[sitrd_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
        end else if (i_cmd.div_step) begin
            r_div <= n_div;
        end
        if (i_cmd.start) begin
            r_base <= i_radix;
        end
        if (i_cmd.start || push) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.start) begin
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + 1'b1;
        end
    end

    // digit stack: least significant digit pushed first, top read at entry zero
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[0] <= n_rem[DIG_W-1:0];
            for (int i = 1; i < sitrd_pkg::STACK_DEPTH; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < sitrd_pkg::STACK_DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (push) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.pop) begin
            r_count <= r_count - 1'b1;
        end
    end

    assign top_idx = sitrd_pkg::SYM_IDX_W'(r_stack[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_char <= i_cmd.out_sign ? sitrd_pkg::CHAR_MINUS : syms[top_idx];
            r_out_last <= !i_cmd.out_sign && (r_count == sitrd_pkg::COUNT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    assign o_status.alpha_ok  = r_alpha_ok;
    assign o_status.div_last  = r_step == STEP_LAST;
    assign o_status.quo_zero  = n_div == '0;
    assign o_status.neg       = r_neg;
    assign o_status.stack_one = r_count == sitrd_pkg::COUNT_W'(1);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count < sitrd_pkg::COUNT_W'(sitrd_pkg::STACK_DEPTH)))
        else $error("digit stack overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("digit stack underflow");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while held");

    a_empty_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (r_count == '0))
        else $error("digit stack not empty at start of conversion");

endmodule

// ===== rtl/core/signed_int_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits
// converts a signed 32-bit integer to text in a configurable radix
// ----------------------------------------------------------------------------
// steps: accept, alphabet check, long division of each digit (8 quotient
//   bits per cycle), then one character per cycle while the receiver is ready
// an invalid alphabet drops the item with no output
// synchronous active-low reset restores radix 10 and alphabet 0-9A-F
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits #(
    parameter int MAX_SYMBOLS = sitrd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sitrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sitrd_pkg::SYM_W-1:0]     i_cfg_wdata,
    // input request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sitrd_pkg::VALUE_W-1:0]   s_axis_tdata,   // [31:0] value
    // character stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sitrd_pkg::CHAR_W-1:0]    m_axis_tdata,   // [7:0] character
    output logic                            m_axis_tlast
);

    // configuration registers
    logic [sitrd_pkg::RADIX_W-1:0] r_radix;
    logic [sitrd_pkg::SYM_W-1:0]   r_symbols_low;
    logic [sitrd_pkg::SYM_W-1:0]   r_symbols_high;

    sitrd_pkg::t_dp_cmd    cmd;
    sitrd_pkg::t_dp_status status;

    // writes to an unused index fall through the default arm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix        <= sitrd_pkg::RADIX_RESET;
            r_symbols_low  <= sitrd_pkg::SYMBOLS_LOW_RESET;
            r_symbols_high <= sitrd_pkg::SYMBOLS_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sitrd_pkg::CFG_RADIX:        r_radix <= i_cfg_wdata[sitrd_pkg::RADIX_W-1:0];
                sitrd_pkg::CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_wdata;
                sitrd_pkg::CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer: one request at a time, ready only between conversions
    sitrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: the output register lets the next request enter while the
    // final character is still waiting downstream
    sitrd_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_value        (s_axis_tdata),
        .i_radix        (r_radix),
        .i_symbols_low  (r_symbols_low),
        .i_symbols_high (r_symbols_high),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_char     (m_axis_tdata),
        .o_out_last     (m_axis_tlast)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the signed integer to radix digits converter: a
// queue-fed driver offers values, a monitor predicts the character text of
// every accepted value and compares each output character and its last flag
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sitrd_pkg::*;

    localparam int MAX_SYM       = MAX_SYMBOLS_DEF;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;   // long receiver back-pressure stretch
    localparam int BATCH_ITEMS   = 34;
    localparam int BATCH_COUNT   = 15;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_exp;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #4 i_clk = ~i_clk;

    // dut ports, inputs driven to known values from time zero
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_RADIX;
    logic [SYM_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [VALUE_W-1:0]   s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    signed_int_to_radix_digits dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow copy of the configuration registers
    logic [RADIX_W-1:0] cur_radix  = RADIX_RESET;
    logic [SYM_W-1:0]   cur_sym_lo = SYMBOLS_LOW_RESET;
    logic [SYM_W-1:0]   cur_sym_hi = SYMBOLS_HIGH_RESET;

    logic [VALUE_W-1:0] pending_values[$];   // requests waiting for the driver
    t_char_exp          expected_chars[$];   // predicted text, oldest first

    int  mismatch_count = 0;
    int  tx_idle_pct    = 0;
    int  rx_idle_pct    = 0;
    logic in_accepted   = 1'b0;   // request taken at the last rising edge
    logic hold_request  = 1'b0;
    logic rx_hold       = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] symbol_of(input logic [SYM_IDX_W-1:0] idx);
        logic [SYM_W-1:0] word;
        word = idx[3] ? cur_sym_hi : cur_sym_lo;
        return word[int'(idx[2:0]) * 8 +: 8];
    endfunction

    // alphabet must hold 2..MAX symbols, all distinct, none of them a sign
    function automatic bit alphabet_usable();
        int n;
        logic [CHAR_W-1:0] a;
        n = int'(cur_radix);
        if (n < 2 || n > MAX_SYM || n > SYM_COUNT)
            return 1'b0;
        for (int i = 0; i < n; i++) begin
            a = symbol_of(i[SYM_IDX_W-1:0]);
            if (a == CHAR_PLUS || a == CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (a == symbol_of(j[SYM_IDX_W-1:0]))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // queues the characters one value turns into, sign first, msd first
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0]   mag;
        logic [VALUE_W-1:0]   base;
        logic [SYM_IDX_W-1:0] digits[$];
        t_char_exp            e;
        if (!alphabet_usable())
            return;
        base = VALUE_W'(cur_radix);
        // magnitude in unsigned arithmetic so the most negative value works
        mag = value[VALUE_W-1] ? (32'd0 - value) : value;
        do begin
            digits.push_front(SYM_IDX_W'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        if (value[VALUE_W-1]) begin
            e.ch   = CHAR_MINUS;
            e.last = 1'b0;
            expected_chars.push_back(e);
        end
        while (digits.size() != 0) begin
            e.ch   = symbol_of(digits.pop_front());
            e.last = (digits.size() == 0);
            expected_chars.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver: new data at the falling edge, held until taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_accepted) begin
            // request still waiting for tready, keep it stable
        end else if (pending_values.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            s_axis_tdata  <= pending_values.pop_front();
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver side ready, random stalls plus the long hold
    always @(negedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long back-pressure stretch, counted here so the sender keeps offering
    initial begin : rx_hold_proc
        wait (hold_request);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // monitor: checks outputs, then predicts for the request taken this edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_exp e;
        if (!i_rst_n) begin
            in_accepted <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %02h last %0b",
                                              m_axis_tdata, m_axis_tlast));
                end else begin
                    e = expected_chars.pop_front();
                    if (m_axis_tdata !== e.ch)
                        report_mismatch($sformatf("char %02h, want %02h",
                                                  m_axis_tdata, e.ch));
                    if (m_axis_tlast !== e.last)
                        report_mismatch($sformatf("last %0b, want %0b on char %02h",
                                                  m_axis_tlast, e.last, e.ch));
                end
            end
            in_accepted <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                predict_text(s_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SYM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_RADIX:        cur_radix  = data[RADIX_W-1:0];
            CFG_SYMBOLS_LOW:  cur_sym_lo = data;
            CFG_SYMBOLS_HIGH: cur_sym_hi = data;
            default: ;   // unmapped index, register file unchanged
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_alphabet(input logic [RADIX_W-1:0] radix,
                                 input logic [SYM_W-1:0] lo, input logic [SYM_W-1:0] hi);
        cfg_write(CFG_RADIX, SYM_W'(radix));
        cfg_write(CFG_SYMBOLS_LOW, lo);
        cfg_write(CFG_SYMBOLS_HIGH, hi);
    endtask

    // block idle: driver empty, all text seen, then the drop latency
    task automatic wait_idle();
        while (pending_values.size() != 0 || s_axis_tvalid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int sel;
        logic [VALUE_W-1:0] v;
        sel = $urandom_range(9);
        case (sel)
            0: begin
                case ($urandom_range(5))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h8000_0001;
                    4:       v = 32'h0000_0001;
                    default: v = 32'h0000_0000;
                endcase
            end
            1, 2:    v = VALUE_W'($urandom_range(600) - 300);
            3, 4:    v = $urandom >> $urandom_range(31);
            default: v = $urandom;
        endcase
        // flip sign on some shifted values so short negatives show up too
        if (sel == 3 && $urandom_range(1))
            v = 32'd0 - v;
        return v;
    endfunction

    // fills a 16-symbol alphabet; the first n symbols are distinct and sign-free
    task automatic make_alphabet(input int n, output logic [SYM_W-1:0] lo,
                                 output logic [SYM_W-1:0] hi);
        logic [CHAR_W-1:0] syms[SYM_COUNT];
        logic [CHAR_W-1:0] c;
        bit clash;
        for (int i = 0; i < SYM_COUNT; i++) begin
            do begin
                c = CHAR_W'($urandom);
                clash = (i < n) && (c == CHAR_PLUS || c == CHAR_MINUS);
                for (int j = 0; j < i && j < n; j++)
                    if (syms[j] == c)
                        clash = 1'b1;
            end while (clash);
            syms[i] = c;
        end
        for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = syms[i];
            hi[i*8 +: 8] = syms[i + 8];
        end
    endtask

    // random configuration; returns 1 when the alphabet is usable
    task automatic random_config(output bit usable);
        logic [SYM_W-1:0] lo, hi;
        int r, pos, src;
        int kind;
        kind = $urandom_range(9);
        r = (kind == 0) ? (($urandom_range(1)) ? $urandom_range(1) : $urandom_range(31, 17))
                        : $urandom_range(2, 16);
        make_alphabet((r >= 2 && r <= 16) ? r : 16, lo, hi);
        if (kind == 1) begin
            // duplicate one in-use symbol onto another
            pos = $urandom_range(r - 1, 1);
            src = $urandom_range(pos - 1);
            if (pos < 8) lo[pos*8 +: 8] = (src < 8) ? lo[src*8 +: 8] : hi[(src-8)*8 +: 8];
            else         hi[(pos-8)*8 +: 8] = (src < 8) ? lo[src*8 +: 8] : hi[(src-8)*8 +: 8];
        end else if (kind == 2) begin
            // a sign character anywhere among the in-use symbols
            pos = $urandom_range(r - 1);
            if (pos < 8) lo[pos*8 +: 8] = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
            else         hi[(pos-8)*8 +: 8] = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
        end
        load_alphabet(RADIX_W'(r), lo, hi);
        usable = alphabet_usable();
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int  batches_done;
        bit  usable;
        logic [SYM_W-1:0] lo, hi;

        batches_done = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(6, 80);

        // reset alphabet, base ten: zero, single digit, extremes
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd7);
        pending_values.push_back(-32'sd7);
        pending_values.push_back(32'd10);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd1_000_000_000);
        wait_idle();

        // base sixteen; a write to the unmapped index must change nothing
        cfg_write(CFG_RADIX, SYM_W'(16));
        cfg_write(CFG_UNMAPPED, {$urandom, $urandom});
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'hDEAD_BEEF);
        wait_idle();

        // base two: longest text, 32 digits plus the sign
        cfg_write(CFG_RADIX, SYM_W'(2));
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        wait_idle();

        // zero byte and high bytes as ordinary symbols
        load_alphabet(5'd3, 64'h3837_3635_3480_FF00, 64'h0);
        pending_values.push_back(32'd0);
        pending_values.push_back(-32'sd5);
        wait_idle();

        // radix out of range on both sides: requests are dropped silently
        cfg_write(CFG_RADIX, SYM_W'(0));
        pending_values.push_back(32'd12);
        wait_idle();
        cfg_write(CFG_RADIX, SYM_W'(1));
        pending_values.push_back(32'd12);
        wait_idle();
        cfg_write(CFG_RADIX, SYM_W'(17));
        pending_values.push_back(32'd12);
        wait_idle();
        cfg_write(CFG_RADIX, SYM_W'(31));
        pending_values.push_back(32'd12);
        wait_idle();

        // repeated symbol
        load_alphabet(5'd4, 64'h0000_0000_4141_4342, 64'h0);
        pending_values.push_back(32'd99);
        wait_idle();
        // plus sign as the very first symbol
        load_alphabet(5'd4, 64'h0000_0000_4344_452B, 64'h0);
        pending_values.push_back(32'd99);
        wait_idle();
        // minus sign as the last in-use symbol, in the upper word
        load_alphabet(5'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_2D38);
        pending_values.push_back(32'd99);
        wait_idle();
        // sign symbols just past the in-use range are fine
        load_alphabet(5'd8, 64'h3736_3534_3332_3130, 64'h2D2B_2D2B_2D2B_2D2B);
        pending_values.push_back(-32'sd4242);
        wait_idle();

        // random batches: three idling regimes, each with fresh alphabets
        while (batches_done < BATCH_COUNT) begin
            if (batches_done < 5)       set_idling(6, 80);
            else if (batches_done < 10) set_idling(80, 6);
            else                        set_idling(0, 0);
            random_config(usable);
            if (!usable) begin
                // dropped requests, not counted toward the batch total
                repeat (5) pending_values.push_back(random_value());
                wait_idle();
                continue;
            end
            repeat (BATCH_ITEMS) pending_values.push_back(random_value());
            // stall the receiver long enough to back the block up
            if (batches_done == 12)
                hold_request = 1'b1;
            wait_idle();
            batches_done++;
        end

        // a fresh random 16-symbol alphabet at the largest radix
        make_alphabet(16, lo, hi);
        load_alphabet(5'd16, lo, hi);
        repeat (10) pending_values.push_back(random_value());
        wait_idle();

        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial begin : watchdog
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
